// ----- hdl/cps_pkg.sv -----
package cps_pkg;

  localparam int CntWidth = 11;
  localparam int DepWidth = 4;

  typedef logic signed [CntWidth-1:0] cnt_t;

  localparam cnt_t CNT_MIN = -11'sd1024;
  localparam cnt_t CNT_MAX = 11'sd1023;

  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_YIELD   = 3'd1,
    ACT_CREATE  = 3'd2,
    ACT_EXIT    = 3'd3,
    ACT_RELEASE = 3'd4,
    ACT_SET     = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_IDLE = 2'd2
  } status_e;

  // one table entry as held in the slot memory
  typedef struct packed {
    cnt_t                cnt;
    logic [DepWidth-1:0] dep;
  } slot_word_t;

  // halve toward zero, add the priority, saturate
  function automatic cnt_t recharge(cnt_t c, logic [7:0] p);
    logic signed [12:0] s;
    s = 13'(c) + $signed({12'b0, c[CntWidth-1]});
    s = s >>> 1;
    s = s + $signed({5'b0, p});
    if (s < 13'(CNT_MIN)) begin
      s = 13'(CNT_MIN);
    end else if (s > 13'(CNT_MAX)) begin
      s = 13'(CNT_MAX);
    end
    return cnt_t'(s[CntWidth-1:0]);
  endfunction

endpackage

// ----- hdl/counter_priority_task_scheduler_core.sv -----
// Counter-based round-robin task scheduler. Each input word carries one action
// (tick, yield, create, exit, preempt release, set state) and yields exactly one
// result word. Run and valid flags live in flops; counters and preempt depths
// live in a single-port-write, registered-read slot memory that one compare
// unit walks one slot per cycle. Create, set state and unused codes go straight
// to the result; preempt release and a tick that does not expire first do a
// read-modify-write of the current slot. Yield, exit and an expiring tick add
// one scan of all slots. When no task has time left they add a second pass
// (recharge fused with the rescan). The input stalls until the result is loaded
// into the output register. Reset leaves the memory unwritten: only slot 0 is
// live then, and it reads as zero until first written.
module counter_priority_task_scheduler_core
  import cps_pkg::*;
#(
  parameter int MAX_TASKS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_wr_en_i,
  input  logic [7:0] cfg_wr_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] action_i,
  input  logic [5:0] task_index_i,
  input  logic       running_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [5:0] current_task_o,
  output logic       switched_o,
  output logic [5:0] new_task_o,
  output logic [1:0] status_o
);

  localparam int SW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_TASKS);
  localparam int WordW = $bits(slot_word_t);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_RECH = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [7:0]           prio_q, prio_d;
  logic [MAX_TASKS-1:0] valid_q, valid_d;
  logic [MAX_TASKS-1:0] run_q, run_d;
  logic [SW-1:0]        cur_q, cur_d;
  logic [CW-1:0]        task_count_q, task_count_d;
  logic                 fresh_q, fresh_d;
  action_e              act_q, act_d;
  logic [CW-1:0]        iss_q, iss_d;
  logic                 pv_q, pv_d;
  logic [SW-1:0]        pa_q, pa_d;
  cnt_t                 best_cnt_q, best_cnt_d;
  logic [SW-1:0]        best_idx_q, best_idx_d;
  logic                 res_sw_q, res_sw_d;
  logic [5:0]           res_new_q, res_new_d;
  status_e              res_st_q, res_st_d;
  logic                 out_vld_q, out_vld_d;
  logic [5:0]           out_cur_q, out_cur_d;
  logic                 out_sw_q, out_sw_d;
  logic [5:0]           out_new_q, out_new_d;
  status_e              out_st_q, out_st_d;

  logic                 ram_we;
  logic [SW-1:0]        ram_waddr;
  slot_word_t           ram_wdata;
  logic [SW-1:0]        ram_raddr;
  logic [WordW-1:0]     ram_rdata;
  slot_word_t           rd_word;

  cps_ram #(
    .Width (WordW),
    .Depth (MAX_TASKS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // slot 0 reads as its reset value until first written
  assign rd_word = (fresh_q && pa_q == '0) ? '0 : slot_word_t'(ram_rdata);

  always_comb begin
    slot_word_t w;
    cnt_t       t;
    cnt_t       nv;
    logic       resched;
    logic [SW-1:0] sidx;

    state_d      = state_q;
    prio_d       = prio_q;
    valid_d      = valid_q;
    run_d        = run_q;
    cur_d        = cur_q;
    task_count_d = task_count_q;
    fresh_d      = fresh_q;
    act_d        = act_q;
    iss_d        = iss_q;
    pv_d         = pv_q;
    pa_d         = pa_q;
    best_cnt_d   = best_cnt_q;
    best_idx_d   = best_idx_q;
    res_sw_d     = res_sw_q;
    res_new_d    = res_new_q;
    res_st_d     = res_st_q;
    out_vld_d    = out_vld_q;
    out_cur_d    = out_cur_q;
    out_sw_d     = out_sw_q;
    out_new_d    = out_new_q;
    out_st_d     = out_st_q;
    ram_we       = 1'b0;
    ram_waddr    = cur_q;
    ram_wdata    = rd_word;
    ram_raddr    = cur_q;
    w            = rd_word;
    t            = rd_word.cnt;
    nv           = rd_word.cnt;
    resched      = 1'b0;
    sidx         = SW'(task_index_i);

    if (cfg_wr_en_i) begin
      prio_d = cfg_wr_data_i;
    end

    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d     = action_e'(action_i);
          pa_d      = cur_q;
          res_new_d = '0;
          res_st_d  = ST_OK;
          res_sw_d  = 1'b0;
          state_d   = S_DONE;
          case (action_e'(action_i)) inside
            ACT_TICK, ACT_YIELD, ACT_EXIT, ACT_RELEASE: begin
              state_d = S_MOD;
            end
            ACT_CREATE: begin
              if (task_count_q >= MaxCnt) begin
                res_st_d = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = task_count_q[SW-1:0];
                ram_wdata = '{cnt: cnt_t'({3'b0, prio_q}), dep: DepWidth'(1)};
                valid_d[task_count_q[SW-1:0]] = 1'b1;
                run_d[task_count_q[SW-1:0]]   = 1'b1;
                task_count_d = task_count_q + CW'(1);
                res_new_d    = 6'(task_count_q);
              end
            end
            ACT_SET: begin
              if (int'(task_index_i) < MAX_TASKS && valid_q[sidx]) begin
                run_d[sidx] = running_i;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_MOD: begin
        // read-modify-write of the current slot
        case (act_q) inside
          ACT_TICK: begin
            t = (w.cnt == CNT_MIN) ? CNT_MIN : w.cnt - cnt_t'(1);
            w.cnt = t;
            if (t <= cnt_t'(0) && w.dep == '0) begin
              w.cnt   = '0;
              resched = 1'b1;
            end
          end
          ACT_YIELD: begin
            w.cnt   = '0;
            resched = 1'b1;
          end
          ACT_EXIT: begin
            w.cnt        = '0;
            run_d[cur_q] = 1'b0;
            resched      = 1'b1;
          end
          ACT_RELEASE: begin
            if (w.dep != '0) begin
              w.dep = w.dep - DepWidth'(1);
            end
          end
          default: begin
          end
        endcase
        ram_we    = 1'b1;
        ram_waddr = cur_q;
        ram_wdata = w;
        if (resched) begin
          iss_d      = '0;
          pv_d       = 1'b0;
          best_cnt_d = '0;
          best_idx_d = cur_q;
          state_d    = S_SCAN;
        end else begin
          state_d = S_DONE;
        end
      end

      S_SCAN, S_RECH: begin
        if (iss_q < MaxCnt) begin
          ram_raddr = iss_q[SW-1:0];
          iss_d     = iss_q + CW'(1);
          pv_d      = 1'b1;
          pa_d      = iss_q[SW-1:0];
        end else begin
          pv_d = 1'b0;
        end
        if (pv_q) begin
          if (state_q == S_RECH && valid_q[pa_q]) begin
            nv        = recharge(rd_word.cnt, prio_q);
            ram_we    = 1'b1;
            ram_waddr = pa_q;
            ram_wdata = '{cnt: nv, dep: rd_word.dep};
          end
          // strict compare keeps the lowest index on ties
          if (valid_q[pa_q] && run_q[pa_q] && nv > best_cnt_q) begin
            best_cnt_d = nv;
            best_idx_d = pa_q;
          end
        end
        if (iss_q == MaxCnt && !pv_q) begin
          if (best_cnt_q > cnt_t'(0)) begin
            cur_d    = best_idx_q;
            res_sw_d = (best_idx_q != cur_q);
            state_d  = S_DONE;
          end else if (state_q == S_SCAN) begin
            iss_d      = '0;
            best_cnt_d = '0;
            state_d    = S_RECH;
          end else begin
            res_st_d = ST_IDLE;
            state_d  = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d = 1'b1;
          out_cur_d = 6'(cur_q);
          out_sw_d  = res_sw_q;
          out_new_d = res_new_q;
          out_st_d  = res_st_q;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (ram_we && ram_waddr == '0) begin
      fresh_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      prio_q       <= 8'd1;
      valid_q      <= MAX_TASKS'(1);
      run_q        <= MAX_TASKS'(1);
      cur_q        <= '0;
      task_count_q <= CW'(1);
      fresh_q      <= 1'b1;
      iss_q        <= '0;
      pv_q         <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      prio_q       <= prio_d;
      valid_q      <= valid_d;
      run_q        <= run_d;
      cur_q        <= cur_d;
      task_count_q <= task_count_d;
      fresh_q      <= fresh_d;
      iss_q        <= iss_d;
      pv_q         <= pv_d;
      out_vld_q    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    pa_q       <= pa_d;
    best_cnt_q <= best_cnt_d;
    best_idx_q <= best_idx_d;
    res_sw_q   <= res_sw_d;
    res_new_q  <= res_new_d;
    res_st_q   <= res_st_d;
    out_cur_q  <= out_cur_d;
    out_sw_q   <= out_sw_d;
    out_new_q  <= out_new_d;
    out_st_q   <= out_st_d;
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_vld_q;
  assign current_task_o = out_cur_q;
  assign switched_o     = out_sw_q;
  assign new_task_o     = out_new_q;
  assign status_o       = out_st_q;

  // the current slot is always a live table entry
  a_cur_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[cur_q])
    else $error("current slot is not valid");

  // slots are handed out in order, so the live set matches the fill count
  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(task_count_q))
    else $error("valid slots disagree with task count");

  // an idle report never moves the current task
  a_idle_no_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_IDLE |-> !switched_o)
    else $error("idle result flagged a switch");

endmodule

// ----- hdl/cps_ram.sv -----
module cps_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
